// ===== design/multichannel_audio_mixer_defines.svh =====
// assertion macros used by the mixer top level
`ifndef MULTICHANNEL_AUDIO_MIXER_DEFINES_SVH
`define MULTICHANNEL_AUDIO_MIXER_DEFINES_SVH

// checked on every clock edge outside reset
`define MAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define MAM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mam_pkg.sv =====
// types, constants and helper functions of the audio mixer
package mam_pkg;

  localparam int SUM_W  = 24;
  localparam int PCM_W  = 16;
  localparam int VOL_W  = 8;
  localparam int MVOL_W = 9;
  localparam int LG_W   = 5;
  localparam int IDX_W  = 16;
  localparam int MUL_A_W = SUM_W + 1;
  localparam int MUL_B_W = MVOL_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_8BIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MONO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE_LOG2 = 3'd3;

  localparam logic [MVOL_W-1:0] MASTER_VOLUME_RESET  = 9'd179;
  localparam logic [LG_W-1:0]   RING_SIZE_LOG2_RESET = 5'd14;
  localparam logic [LG_W-1:0]   RING_LG_MIN          = 5'd2;
  localparam logic [LG_W-1:0]   RING_LG_MAX          = 5'd16;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7fffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sh800000;
  localparam logic [PCM_W-1:0] PCM_MAX = 16'h7fff;
  localparam logic [PCM_W-1:0] PCM_MIN = 16'h8000;
  localparam logic [7:0] U8_OFFSET = 8'd128;

  typedef struct packed {
    logic                       load;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

  // add a channel term to a sum and clamp to the 24-bit range
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   sum,
    input logic signed [MUL_A_W-1:0] term
  );
    logic signed [MUL_A_W:0] r;
    r = (MUL_A_W+1)'(sum) + (MUL_A_W+1)'(term);
    if (r > (MUL_A_W+1)'(SUM_MAX)) begin
      return SUM_MAX;
    end else if (r < (MUL_A_W+1)'(SUM_MIN)) begin
      return SUM_MIN;
    end
    return r[SUM_W-1:0];
  endfunction

  // master-scaled product to pcm: floor shift, clamp, optional 8-bit form
  function automatic logic [PCM_W-1:0] finish_pcm(
    input logic signed [PROD_W-1:0] prod,
    input logic                     out8
  );
    logic signed [PROD_W-9:0] v;
    logic [PCM_W-1:0]         pcm;
    v = prod[PROD_W-1:8];
    if (v > (PROD_W-8)'(signed'({1'b0, PCM_MAX}))) begin
      pcm = PCM_MAX;
    end else if (v < -(PROD_W-8)'(signed'({1'b0, PCM_MIN}))) begin
      pcm = PCM_MIN;
    end else begin
      pcm = v[PCM_W-1:0];
    end
    if (out8) begin
      return {8'd0, 8'(pcm[PCM_W-1:8] + U8_OFFSET)};
    end
    return pcm;
  endfunction

endpackage

// ===== design/mam_mult.sv =====
// shared signed multiplier with registered product
module mam_mult
  import mam_pkg::*;
(
  input  logic                     clk,
  input  mul_req_t                 req,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

endmodule

// ===== design/multichannel_audio_mixer.sv =====
// Mixer top level: one channel sample per input transaction, summed into left and right
// accumulators; the transaction marked last_of_frame scales both sums by the master
// volume, saturates them and emits one output transaction with the ring index. One
// signed multiplier is shared by every product, so an active input transaction passes
// ST_TERM_L, ST_TERM_R and ST_ADD_R before in_ready returns (an inactive one stays in
// ST_IDLE); a frame close adds ST_FIN_L, ST_FIN_R and ST_EMIT, held until the output is free.
`include "multichannel_audio_mixer_defines.svh"

module multichannel_audio_mixer
  import mam_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [PCM_W-1:0]      sample,
  input  logic                         source_8bit,
  input  logic [VOL_W-1:0]             left_volume,
  input  logic [VOL_W-1:0]             right_volume,
  input  logic                         active,
  input  logic                         last_of_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PCM_W-1:0]      left_pcm,
  output logic signed [PCM_W-1:0]      right_pcm,
  output logic [IDX_W-1:0]             ring_index
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TERM_L = 3'd1;
  localparam logic [2:0] ST_TERM_R = 3'd2;
  localparam logic [2:0] ST_ADD_R  = 3'd3;
  localparam logic [2:0] ST_FIN_L  = 3'd4;
  localparam logic [2:0] ST_FIN_R  = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state, state_next;

  logic [MVOL_W-1:0] master_volume;
  logic              output_8bit;
  logic              output_mono;
  logic [LG_W-1:0]   ring_size_log2;

  logic signed [PCM_W-1:0] smp;
  logic                    is8;
  logic [VOL_W-1:0]        lvol, rvol;
  logic                    last;

  logic signed [SUM_W-1:0] sum_left, sum_right;
  logic [IDX_W-1:0]        write_position;
  logic [PCM_W-1:0]        left_fin;

  mul_req_t                req;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_A_W-1:0] term;
  logic signed [MUL_A_W-1:0] smp_ext;
  logic [VOL_W-1:0]         vol_sel;
  logic                     accept, emit_load;
  logic [LG_W-1:0]          lg;
  logic [IDX_W:0]           mask;
  logic [IDX_W-1:0]         idx;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_load = (state == ST_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume  <= MASTER_VOLUME_RESET;
      output_8bit    <= 1'b0;
      output_mono    <= 1'b0;
      ring_size_log2 <= RING_SIZE_LOG2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASTER_VOLUME:  master_volume  <= cfg_data[MVOL_W-1:0];
        REG_OUTPUT_8BIT:    output_8bit    <= cfg_data[0];
        REG_OUTPUT_MONO:    output_mono    <= cfg_data[0];
        REG_RING_SIZE_LOG2: ring_size_log2 <= cfg_data[LG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp  <= sample;
      is8  <= source_8bit;
      lvol <= left_volume;
      rvol <= right_volume;
      last <= last_of_frame;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (active) begin
            state_next = ST_TERM_L;
          end else if (last_of_frame) begin
            state_next = ST_FIN_L;
          end
        end
      end
      ST_TERM_L: state_next = ST_TERM_R;
      ST_TERM_R: state_next = ST_ADD_R;
      ST_ADD_R:  state_next = last ? ST_FIN_L : ST_IDLE;
      ST_FIN_L:  state_next = ST_FIN_R;
      ST_FIN_R:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand select for the shared multiplier
  assign smp_ext = is8 ? MUL_A_W'(signed'(smp[7:0])) : MUL_A_W'(smp);

  always_comb begin
    vol_sel = (state == ST_TERM_R) ? rvol : lvol;
    if (is8) begin
      vol_sel = {vol_sel[VOL_W-1:3], 3'b000};
    end
  end

  always_comb begin
    req.load = 1'b0;
    req.a    = '0;
    req.b    = '0;
    unique case (state)
      ST_TERM_L, ST_TERM_R: begin
        req.load = 1'b1;
        req.a    = smp_ext;
        req.b    = signed'({2'b00, vol_sel});
      end
      ST_FIN_L: begin
        req.load = 1'b1;
        req.a    = MUL_A_W'(sum_left);
        req.b    = signed'({1'b0, master_volume});
      end
      ST_FIN_R: begin
        req.load = 1'b1;
        req.a    = MUL_A_W'(sum_right);
        req.b    = signed'({1'b0, master_volume});
      end
      default: ;
    endcase
  end

  mam_mult u_mult (
    .clk  (clk),
    .req  (req),
    .prod (prod)
  );

  // 16-bit sources take the floor of product / 256, 8-bit sources the product
  assign term = is8 ? prod[MUL_A_W-1:0] : prod[MUL_A_W+7:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_left       <= '0;
      sum_right      <= '0;
      write_position <= '0;
    end else if (emit_load) begin
      sum_left       <= '0;
      sum_right      <= '0;
      write_position <= write_position + 16'd1;
    end else if (state == ST_TERM_R) begin
      sum_left <= sat_add(sum_left, term);
    end else if (state == ST_ADD_R) begin
      sum_right <= sat_add(sum_right, term);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN_R) begin
      left_fin <= finish_pcm(prod, output_8bit);
    end
  end

  // ring index wraps at the clamped ring size
  always_comb begin
    lg = ring_size_log2;
    if (lg < RING_LG_MIN) begin
      lg = RING_LG_MIN;
    end else if (lg > RING_LG_MAX) begin
      lg = RING_LG_MAX;
    end
    mask = (17'd1 << lg) - 17'd1;
    idx  = output_mono ? write_position : {write_position[IDX_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      left_pcm   <= left_fin;
      right_pcm  <= output_mono ? '0 : finish_pcm(prod, output_8bit);
      ring_index <= idx & mask[IDX_W-1:0];
    end
  end

  `MAM_ASSERT_RST(a_reset_idle, rst |=> (state == ST_IDLE) && !out_valid, "not idle after reset")
  `MAM_ASSERT(a_sums_cleared, emit_load |=> (sum_left == '0) && (sum_right == '0), "sums not cleared")
  `MAM_ASSERT(a_pos_step, emit_load |=> write_position == $past(write_position) + 16'd1, "position")
  `MAM_ASSERT(a_u8_range, (emit_load && output_8bit) |=> left_pcm[15:8] == 8'd0, "8-bit range")
  `MAM_ASSERT(a_emit_waits, (state == ST_EMIT) && out_valid && !out_ready |=> state == ST_EMIT, "emit")

endmodule
